// ===== sv/vrt_pkg.sv =====
// Shared types and constants of the virtual region tracker.
// Used by vrt_cell, vrt_ctrl, virtual_region_tracker_unit and the testbench; depends on nothing.
`default_nettype none

package vrt_pkg;

   localparam int MAX_REGIONS_DEF = 64;

   // Request codes carried in req_tuser.
   localparam logic [2:0] CMD_FIXED    = 3'd0;
   localparam logic [2:0] CMD_ANY      = 3'd1;
   localparam logic [2:0] CMD_QUERY    = 3'd2;
   localparam logic [2:0] CMD_DECOMMIT = 3'd3;
   localparam logic [2:0] CMD_RELEASE  = 3'd4;

   // Configuration register indexes.
   localparam int          CSR_IDX_W       = 3;
   localparam logic [2:0] CSR_WINDOW_BASE = 3'd0;
   localparam logic [2:0] CSR_WINDOW_END  = 3'd1;
   localparam logic [2:0] CSR_PAGE_SHIFT  = 3'd2;
   localparam logic [2:0] CSR_HEAP_READY  = 3'd3;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
      logic        committed;
   } entry_type;

   typedef struct packed {
      logic [31:0] window_base;
      logic [31:0] window_end;
      logic [4:0]  page_shift;
      logic        heap_ready;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] req_addr;
      logic [31:0] req_size;
      logic        want_commit;
      logic        top_down;
      logic        zero_fresh;
   } req_type;

   // First member is the most significant; ok lands in bit 0 of tdata.
   typedef struct packed {
      logic        zero_needed;
      logic        was_committed;
      logic        reserved;
      logic        committed;
      logic [31:0] allocation_base;
      logic [31:0] region_size;
      logic [31:0] region_base;
      logic        ok;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MODIFY,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      EDIT_NONE,
      EDIT_INSERT,
      EDIT_DELETE,
      EDIT_SET_COMMIT,
      EDIT_CLEAR_COMMIT
   } edit_type;

endpackage

`default_nettype wire

// ===== sv/virtual_region_tracker_unit.sv =====
// Top level of the virtual region tracker: stream ports, configuration registers,
// the ring of vrt_cell slots and the vrt_ctrl sequencer. Depends on vrt_pkg.
`default_nettype none

// The unit keeps a table of up to MAX_REGIONS guest address regions, sorted by
// base, in a ring of cells that all shift toward slot zero when the table is
// walked. Every request takes one full walk of the ring to gather the facts it
// needs, a decide step, and, when the table changes (an insert, a removal or a
// change of a commit mark), a second full walk that writes the edited table back
// through the tail of the ring. The ring is walked one slot per cycle. One
// request is served at a time. The result is held in an output register, so a
// new request is taken as soon as the previous result has been placed there,
// even if the consumer has not yet taken it. Configuration writes are taken in
// every cycle and should only be made while no request is outstanding.

module virtual_region_tracker_unit
   import vrt_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request stream.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // req_addr[31:0], req_size[63:32], want_commit[64], top_down[65],
   // zero_fresh[66], zero fill above.
   input  wire logic [71:0]          req_tdata,
   // cmd[2:0].
   input  wire logic [2:0]           req_tuser,
   // Result stream.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // ok[0], region_base[32:1], region_size[64:33], allocation_base[96:65],
   // committed[97], reserved[98], was_committed[99], zero_needed[100].
   output logic [103:0]              rsp_tdata,
   // Configuration writes.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   cfg_type   cfg_ff;
   req_type   req;
   rsp_type   rsp_next, rsp_ff;
   logic      rsp_valid_ff, rsp_load, shift;
   entry_type tail;
   entry_type cell_q [MAX_REGIONS];

   assign csr_ready = 1'b1;

   // Configuration registers; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_base <= 32'd0;
         cfg_ff.window_end  <= 32'd0;
         cfg_ff.page_shift  <= 5'd12;
         cfg_ff.heap_ready  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_BASE: cfg_ff.window_base <= csr_data;
            CSR_WINDOW_END:  cfg_ff.window_end  <= csr_data;
            CSR_PAGE_SHIFT:  cfg_ff.page_shift  <= csr_data[4:0];
            CSR_HEAP_READY:  cfg_ff.heap_ready  <= csr_data[0];
            default:         cfg_ff.heap_ready  <= cfg_ff.heap_ready;
         endcase
      end
   end

   assign req = '{cmd: req_tuser, req_addr: req_tdata[31:0], req_size: req_tdata[63:32],
                  want_commit: req_tdata[64], top_down: req_tdata[65],
                  zero_fresh: req_tdata[66]};

   // The ring: each slot loads its upper neighbor, the top slot loads the tail
   // that the sequencer drives, and slot zero is the head it reads.
   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_ring
      entry_type cell_d;
      if (i == MAX_REGIONS - 1) begin : g_top
         assign cell_d = tail;
      end else begin : g_mid
         assign cell_d = cell_q[i + 1];
      end
      vrt_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .entry_in  (cell_d),
         .entry_out (cell_q[i])
      );
   end

   vrt_ctrl #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .head      (cell_q[0]),
      .next      (cell_q[1]),
      .tail      (tail),
      .shift     (shift),
      .rsp_free  (!rsp_valid_ff || rsp_tready),
      .rsp_load  (rsp_load),
      .rsp       (rsp_next)
   );

   // Output register: a finished result waits here for its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff};

endmodule

`default_nettype wire

// ===== sv/vrt_cell.sv =====
// One table slot of the region ring: holds an entry and takes its neighbor's on a shift.
// Depends on vrt_pkg.
`default_nettype none

module vrt_cell
   import vrt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      shift,
   input  wire entry_type entry_in,
   output entry_type      entry_out
);

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

// ===== sv/vrt_ctrl.sv =====
// Sequencer: scans the region ring, decides, then on an edit rewrites it in one pass.
// Depends on vrt_pkg; drives the tail of the vrt_cell ring.
`default_nettype none

module vrt_ctrl
   import vrt_pkg::*;
#(
   parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire req_type   req,
   input  wire entry_type head,
   input  wire entry_type next,
   output entry_type      tail,
   output logic           shift,
   input  wire logic      rsp_free,
   output logic           rsp_load,
   output rsp_type        rsp
);

   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam logic [CW-1:0] LAST_K = CW'(MAX_REGIONS - 1);
   localparam logic [CW-1:0] FULL   = CW'(MAX_REGIONS);

   state_type state_ff, state_in;
   logic [CW-1:0] k_ff, k_in, count_ff, count_in;
   req_type req_ff, req_in;

   logic ex_hit_ff, ex_hit_in, ex_cm_ff, ex_cm_in;
   logic [IW-1:0] ex_idx_ff, ex_idx_in;
   logic ct_hit_ff, ct_hit_in, ct_cm_ff, ct_cm_in;
   logic [IW-1:0] ct_idx_ff, ct_idx_in;
   logic clash_ff, clash_in;
   logic [32:0] cur_ff, cur_in;
   logic bfound_ff, bfound_in;
   logic [31:0] bplace_ff, bplace_in;
   logic [32:0] prev_e_ff, prev_e_in;
   logic tfound_ff, tfound_in;
   logic [31:0] tplace_ff, tplace_in, base0_ff, base0_in;
   logic q_hit_ff, q_hit_in, q_cm_ff, q_cm_in;
   logic [IW-1:0] q_idx_ff, q_idx_in;
   logic [31:0] q_base_ff, q_base_in, q_size_ff, q_size_in;
   logic rb_hit_ff, rb_hit_in;
   logic [IW-1:0] rb_idx_ff, rb_idx_in;
   logic [31:0] rb_size_ff, rb_size_in;
   logic bnd_found_ff, bnd_found_in;
   logic [31:0] bound_ff, bound_in;

   edit_type edit_ff, edit_in;
   logic [IW-1:0] edit_idx_ff, edit_idx_in;
   entry_type ins_ff, ins_in, hold_ff, hold_in;
   logic ins_done_ff, ins_done_in;
   rsp_type rsp_ff, rsp_in;
   logic slice_ff, slice_in;
   logic [31:0] slice_v_ff, slice_v_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (k_ff == LAST_K) state_in = ST_DECIDE;
         ST_DECIDE: state_in = (edit_in != EDIT_NONE) ? ST_MODIFY : ST_DONE;
         ST_MODIFY: if (k_ff == LAST_K) state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_ready = 1'b0;
      shift     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   shift = 1'b1;
         ST_MODIFY: shift = 1'b1;
         ST_DONE:   rsp_load = rsp_free;
         default:   req_ready = 1'b0;
      endcase
   end

   // Slice rounding of a query on a free address is finished on the way out.
   logic [32:0] pm33, r33;
   logic [31:0] pmask;
   always_comb begin
      pm33  = (33'd1 << cfg.page_shift) - 33'd1;
      pmask = ~pm33[31:0];
      r33   = ({1'b0, slice_v_ff} + pm33) & ~pm33;
      rsp   = rsp_ff;
      if (slice_ff) begin
         rsp.region_size = r33[32] ? pmask : r33[31:0];
      end
   end

   logic [32:0] e33, end_r, addr33, size33, wb33, we33, h33, h0_33;
   logic [31:0] h32, h0, any_place;
   logic ent_valid, fixed_pre, any_pre, any_found, f_hit, f_cm;
   logic [IW-1:0] f_idx, kx;
   logic last_fit_ok, bot_end_ok, fb_ok;

   always_comb begin
      req_in = req_ff; k_in = k_ff; count_in = count_ff;
      ex_hit_in = ex_hit_ff; ex_cm_in = ex_cm_ff; ex_idx_in = ex_idx_ff;
      ct_hit_in = ct_hit_ff; ct_cm_in = ct_cm_ff; ct_idx_in = ct_idx_ff;
      clash_in = clash_ff; cur_in = cur_ff; bfound_in = bfound_ff; bplace_in = bplace_ff;
      prev_e_in = prev_e_ff; tfound_in = tfound_ff; tplace_in = tplace_ff;
      base0_in = base0_ff;
      q_hit_in = q_hit_ff; q_cm_in = q_cm_ff; q_idx_in = q_idx_ff;
      q_base_in = q_base_ff; q_size_in = q_size_ff;
      rb_hit_in = rb_hit_ff; rb_idx_in = rb_idx_ff; rb_size_in = rb_size_ff;
      bnd_found_in = bnd_found_ff; bound_in = bound_ff;
      edit_in = edit_ff; edit_idx_in = edit_idx_ff; ins_in = ins_ff; hold_in = hold_ff;
      ins_done_in = ins_done_ff; rsp_in = rsp_ff; slice_in = slice_ff;
      slice_v_in = slice_v_ff;
      tail = head;

      addr33 = {1'b0, req_ff.req_addr};
      size33 = {1'b0, req_ff.req_size};
      wb33   = {1'b0, cfg.window_base};
      we33   = {1'b0, cfg.window_end};
      e33    = {1'b0, head.base} + {1'b0, head.size};
      end_r  = addr33 + size33;
      ent_valid = (k_ff < count_ff);
      kx  = k_ff[IW-1:0];
      h32 = (cfg.window_end < head.base) ? cfg.window_end : head.base;
      h33 = {1'b0, h32};

      // Decision terms, used in the decide cycle only.
      h0 = (count_ff != '0 && base0_ff < cfg.window_end) ? base0_ff : cfg.window_end;
      h0_33 = {1'b0, h0};
      last_fit_ok = (count_ff != '0) && (prev_e_ff <= we33) &&
                    (we33 - prev_e_ff >= size33);
      bot_end_ok  = (cur_ff <= we33) && (we33 - cur_ff >= size33);
      fb_ok       = (wb33 <= h0_33) && (h0_33 - wb33 >= size33);
      fixed_pre = cfg.heap_ready && req_ff.req_size != 32'd0 &&
                  req_ff.req_addr >= cfg.window_base && end_r <= we33;
      any_pre   = cfg.heap_ready && req_ff.req_size != 32'd0 &&
                  cfg.window_end >= cfg.window_base &&
                  req_ff.req_size <= cfg.window_end - cfg.window_base &&
                  count_ff < FULL;
      f_hit = ex_hit_ff || ct_hit_ff;
      f_idx = ex_hit_ff ? ex_idx_ff : ct_idx_ff;
      f_cm  = ex_hit_ff ? ex_cm_ff : ct_cm_ff;
      if (req_ff.top_down) begin
         any_found = tfound_ff || last_fit_ok || fb_ok;
         if (last_fit_ok)    any_place = cfg.window_end - req_ff.req_size;
         else if (tfound_ff) any_place = tplace_ff;
         else                any_place = h0 - req_ff.req_size;
      end else begin
         any_found = bfound_ff || bot_end_ok;
         any_place = bfound_ff ? bplace_ff : cur_ff[31:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req; k_in = '0;
               ex_hit_in = 1'b0; ct_hit_in = 1'b0; clash_in = 1'b0;
               cur_in = {1'b0, cfg.window_base}; bfound_in = 1'b0; tfound_in = 1'b0;
               q_hit_in = 1'b0; rb_hit_in = 1'b0; bnd_found_in = 1'b0;
               slice_in = 1'b0;
            end
         end
         ST_SCAN: begin
            k_in = (k_ff == LAST_K) ? '0 : k_ff + 1'b1;
            if (ent_valid) begin
               if (!ex_hit_ff && head.base == req_ff.req_addr &&
                   head.size == req_ff.req_size) begin
                  ex_hit_in = 1'b1; ex_idx_in = kx; ex_cm_in = head.committed;
               end
               if (!ct_hit_ff && req_ff.req_addr >= head.base && end_r <= e33) begin
                  ct_hit_in = 1'b1; ct_idx_in = kx; ct_cm_in = head.committed;
               end
               if ({1'b0, head.base} < end_r && addr33 < e33) clash_in = 1'b1;
               // Bottom-up first fit.
               if (!bfound_ff) begin
                  if (cur_ff <= {1'b0, head.base} &&
                      {1'b0, head.base} - cur_ff >= size33) begin
                     bfound_in = 1'b1; bplace_in = cur_ff[31:0];
                  end else if (e33 > cur_ff) begin
                     cur_in = e33;
                  end
               end
               // Top-down: the gap above the previous entry, highest one wins.
               if (k_ff == '0) begin
                  base0_in = head.base;
               end else if (prev_e_ff <= h33 && h33 - prev_e_ff >= size33) begin
                  tfound_in = 1'b1; tplace_in = h32 - req_ff.req_size;
               end
               prev_e_in = e33;
               if (!q_hit_ff && req_ff.req_addr >= head.base && addr33 < e33) begin
                  q_hit_in = 1'b1; q_idx_in = kx; q_cm_in = head.committed;
                  q_base_in = head.base; q_size_in = head.size;
               end
               if (!rb_hit_ff && head.base == req_ff.req_addr) begin
                  rb_hit_in = 1'b1; rb_idx_in = kx; rb_size_in = head.size;
               end
               if (!bnd_found_ff && head.base > req_ff.req_addr) begin
                  bnd_found_in = 1'b1; bound_in = head.base;
               end
            end
         end
         ST_DECIDE: begin
            k_in = '0; ins_done_in = 1'b0; edit_in = EDIT_NONE; rsp_in = '0;
            ins_in = '{base: req_ff.req_addr, size: req_ff.req_size,
                       committed: req_ff.want_commit};
            case (req_ff.cmd)
               CMD_FIXED: begin
                  rsp_in.region_base = req_ff.req_addr;
                  rsp_in.region_size = req_ff.req_size;
                  if (fixed_pre && f_hit) begin
                     rsp_in.ok = 1'b1;
                     if (req_ff.want_commit && !f_cm) begin
                        edit_in = EDIT_SET_COMMIT; edit_idx_in = f_idx;
                        rsp_in.zero_needed = req_ff.zero_fresh;
                     end else if (req_ff.want_commit) begin
                        rsp_in.was_committed = 1'b1;
                     end
                  end else if (fixed_pre && !clash_ff && count_ff < FULL) begin
                     rsp_in.ok = 1'b1; edit_in = EDIT_INSERT;
                     rsp_in.zero_needed = req_ff.want_commit && req_ff.zero_fresh;
                  end
               end
               CMD_ANY: begin
                  rsp_in.region_size = req_ff.req_size;
                  if (any_pre && any_found) begin
                     rsp_in.ok = 1'b1; rsp_in.region_base = any_place;
                     ins_in.base = any_place; edit_in = EDIT_INSERT;
                     rsp_in.zero_needed = req_ff.want_commit && req_ff.zero_fresh;
                  end
               end
               CMD_QUERY: begin
                  if (q_hit_ff) begin
                     rsp_in.ok = 1'b1; rsp_in.region_base = q_base_ff;
                     rsp_in.region_size = q_size_ff; rsp_in.allocation_base = q_base_ff;
                     rsp_in.committed = q_cm_ff; rsp_in.reserved = 1'b1;
                  end else if (req_ff.req_addr >= cfg.window_base &&
                               req_ff.req_addr < cfg.window_end) begin
                     rsp_in.ok = 1'b1;
                     rsp_in.region_base = req_ff.req_addr & pmask;
                     slice_in = 1'b1;
                     slice_v_in = (bnd_found_ff ? bound_ff : cfg.window_end) -
                                  (req_ff.req_addr & pmask);
                  end
               end
               CMD_DECOMMIT: begin
                  rsp_in.region_base = req_ff.req_addr;
                  if (q_hit_ff) begin
                     rsp_in.ok = 1'b1; rsp_in.region_size = q_size_ff;
                     edit_in = EDIT_CLEAR_COMMIT; edit_idx_in = q_idx_ff;
                  end
               end
               CMD_RELEASE: begin
                  rsp_in.region_base = req_ff.req_addr;
                  if (rb_hit_ff) begin
                     rsp_in.ok = 1'b1; rsp_in.region_size = rb_size_ff;
                     edit_in = EDIT_DELETE; edit_idx_in = rb_idx_ff;
                  end
               end
               default: rsp_in = '0;
            endcase
         end
         ST_MODIFY: begin
            k_in = (k_ff == LAST_K) ? '0 : k_ff + 1'b1;
            case (edit_ff)
               EDIT_INSERT: begin
                  if (!ins_done_ff && (k_ff == count_ff ||
                      (ent_valid && head.base >= ins_ff.base))) begin
                     tail = ins_ff; hold_in = head; ins_done_in = 1'b1;
                  end else if (ins_done_ff) begin
                     tail = hold_ff; hold_in = head;
                  end
               end
               EDIT_DELETE: begin
                  if (k_ff >= CW'(edit_idx_ff)) tail = next;
               end
               EDIT_SET_COMMIT: begin
                  if (kx == edit_idx_ff) tail.committed = 1'b1;
               end
               EDIT_CLEAR_COMMIT: begin
                  if (kx == edit_idx_ff) tail.committed = 1'b0;
               end
               default: tail = head;
            endcase
            if (k_ff == LAST_K) begin
               if (edit_ff == EDIT_INSERT) count_in = count_ff + 1'b1;
               if (edit_ff == EDIT_DELETE) count_in = count_ff - 1'b1;
            end
         end
         default: tail = head;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         count_ff <= '0;
         edit_ff  <= EDIT_NONE;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         count_ff <= count_in;
         edit_ff  <= edit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      ex_hit_ff <= ex_hit_in; ex_cm_ff <= ex_cm_in; ex_idx_ff <= ex_idx_in;
      ct_hit_ff <= ct_hit_in; ct_cm_ff <= ct_cm_in; ct_idx_ff <= ct_idx_in;
      clash_ff <= clash_in; cur_ff <= cur_in; bfound_ff <= bfound_in;
      bplace_ff <= bplace_in; prev_e_ff <= prev_e_in; tfound_ff <= tfound_in;
      tplace_ff <= tplace_in; base0_ff <= base0_in;
      q_hit_ff <= q_hit_in; q_cm_ff <= q_cm_in; q_idx_ff <= q_idx_in;
      q_base_ff <= q_base_in; q_size_ff <= q_size_in;
      rb_hit_ff <= rb_hit_in; rb_idx_ff <= rb_idx_in; rb_size_ff <= rb_size_in;
      bnd_found_ff <= bnd_found_in; bound_ff <= bound_in;
      edit_idx_ff <= edit_idx_in; ins_ff <= ins_in; hold_ff <= hold_in;
      ins_done_ff <= ins_done_in; rsp_ff <= rsp_in; slice_ff <= slice_in;
      slice_v_ff <= slice_v_in;
   end

   // The table never holds more regions than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL) else $error("region count above table size");

   // A rewrite pass only runs when there is an edit to apply.
   a_modify_edit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODIFY |-> edit_ff != EDIT_NONE)
      else $error("rewrite pass without an edit");

   // An accepted request always starts with a full scan from slot zero.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && req_valid |=> state_ff == ST_SCAN && k_ff == '0)
      else $error("scan did not start at slot zero");

   // The count only moves at the last step of a rewrite pass.
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == ST_MODIFY &&
      $past(k_ff) == LAST_K) else $error("region count changed outside a rewrite");

endmodule

`default_nettype wire

// ===== tb/virtual_region_tracker_unit_tb.sv =====
// Self-checking testbench for virtual_region_tracker_unit: directed and random requests
// against a built-in predictor of the sorted region table. Depends on vrt_pkg and the RTL.
`default_nettype none

module virtual_region_tracker_unit_tb;
   import vrt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = MAX_REGIONS_DEF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [71:0]          req_tdata = '0;
   logic [2:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [103:0]         rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   virtual_region_tracker_unit uut (.*);

   // The 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the register file.
   logic [31:0] win_lo, win_hi;
   logic [4:0]  pg_shift;
   logic        heap_on;

   // Shadow copy of the region table, kept sorted by base.
   logic [31:0] reg_base [SLOTS];
   logic [31:0] reg_size [SLOTS];
   logic        reg_comm [SLOTS];
   int          reg_count;

   rsp_type     pending_rsp[$];
   int          mismatches;
   bit          calm;          // when set, neither side idles
   int          rsp_hold;

   function automatic logic [32:0] region_end(int i);
      return {1'b0, reg_base[i]} + {1'b0, reg_size[i]};
   endfunction

   function automatic bit span_fits(logic [32:0] lo, logic [32:0] hi, logic [31:0] sz);
      return hi >= lo && hi - lo >= {1'b0, sz};
   endfunction

   function automatic bit add_region(logic [31:0] b, logic [31:0] s, logic c);
      int pos;
      pos = 0;
      if (reg_count >= SLOTS) return 1'b0;
      while (pos < reg_count && reg_base[pos] < b) pos++;
      for (int i = reg_count; i > pos; i--) begin
         reg_base[i] = reg_base[i-1];
         reg_size[i] = reg_size[i-1];
         reg_comm[i] = reg_comm[i-1];
      end
      reg_base[pos] = b;
      reg_size[pos] = s;
      reg_comm[pos] = c;
      reg_count++;
      return 1'b1;
   endfunction

   // Marks region i committed on request; fills in the commit flags of the result.
   function automatic void mark_commit(int i, logic c, logic z, inout rsp_type r);
      if (c && !reg_comm[i]) begin
         reg_comm[i] = 1'b1;
         r.zero_needed = z;
      end else if (c) begin
         r.was_committed = 1'b1;
      end
   endfunction

   // Applies one request to the shadow table and returns the result it must give.
   function automatic rsp_type serve_request(logic [2:0] op, logic [31:0] a, logic [31:0] s,
                                             logic c, logic td, logic z);
      rsp_type     r;
      logic [32:0] fin, cur, hi33;
      logic [31:0] hi, place, bound, pmask, sbase;
      logic [63:0] v, rounded;
      bit          done, clash, found;
      r = '0;
      case (op)
         CMD_FIXED: begin
            fin = {1'b0, a} + {1'b0, s};
            r.region_base = a;
            r.region_size = s;
            if (heap_on && s != 0 && a >= win_lo && fin <= {1'b0, win_hi}) begin
               done = 1'b0;
               for (int i = 0; i < reg_count && !done; i++)
                  if (reg_base[i] == a && reg_size[i] == s) begin
                     mark_commit(i, c, z, r);
                     done = 1'b1;
                  end
               for (int i = 0; i < reg_count && !done; i++)
                  if (a >= reg_base[i] && fin <= region_end(i)) begin
                     mark_commit(i, c, z, r);
                     done = 1'b1;
                  end
               if (done) r.ok = 1'b1;
               else begin
                  clash = 1'b0;
                  for (int i = 0; i < reg_count; i++)
                     if ({1'b0, reg_base[i]} < fin && {1'b0, a} < region_end(i)) clash = 1'b1;
                  if (!clash && add_region(a, s, c)) begin
                     r.ok = 1'b1;
                     r.zero_needed = c && z;
                  end
               end
            end
         end
         CMD_ANY: begin
            r.region_size = s;
            if (heap_on && s != 0 && win_hi >= win_lo && s <= win_hi - win_lo &&
                reg_count < SLOTS) begin
               found = 1'b0;
               place = '0;
               if (!td) begin
                  cur = {1'b0, win_lo};
                  for (int i = 0; i < reg_count && !found; i++) begin
                     if (span_fits(cur, {1'b0, reg_base[i]}, s)) begin
                        found = 1'b1;
                        place = cur[31:0];
                     end else if (region_end(i) > cur) cur = region_end(i);
                  end
                  if (!found && span_fits(cur, {1'b0, win_hi}, s)) begin
                     found = 1'b1;
                     place = cur[31:0];
                  end
               end else begin
                  hi = win_hi;
                  for (int i = reg_count; i > 0 && !found; i--) begin
                     hi33 = {1'b0, hi};
                     if (span_fits(region_end(i-1), hi33, s)) begin
                        found = 1'b1;
                        place = hi - s;
                     end else if (reg_base[i-1] < hi) hi = reg_base[i-1];
                  end
                  if (!found && span_fits({1'b0, win_lo}, {1'b0, hi}, s)) begin
                     found = 1'b1;
                     place = hi - s;
                  end
               end
               if (found && add_region(place, s, c)) begin
                  r.ok = 1'b1;
                  r.region_base = place;
                  r.zero_needed = c && z;
               end
            end
         end
         CMD_QUERY: begin
            done = 1'b0;
            for (int i = 0; i < reg_count && !done; i++)
               if (a >= reg_base[i] && {1'b0, a} < region_end(i)) begin
                  done = 1'b1;
                  r.ok = 1'b1;
                  r.region_base = reg_base[i];
                  r.region_size = reg_size[i];
                  r.allocation_base = reg_base[i];
                  r.committed = reg_comm[i];
                  r.reserved = 1'b1;
               end
            if (!done && a >= win_lo && a < win_hi) begin
               bound = win_hi;
               pmask = ~((32'd1 << pg_shift) - 32'd1);
               sbase = a & pmask;
               for (int i = 0; i < reg_count; i++)
                  if (reg_base[i] > a) begin
                     bound = reg_base[i];
                     break;
                  end
               v = {32'd0, bound} - {32'd0, sbase};
               rounded = (v + (64'd1 << pg_shift) - 64'd1) & ~((64'd1 << pg_shift) - 64'd1);
               // A slice that rounds past 32 bits is clipped to the top page multiple.
               if (rounded > 64'hFFFF_FFFF) rounded = {32'd0, pmask};
               r.ok = 1'b1;
               r.region_base = sbase;
               r.region_size = rounded[31:0];
            end
         end
         CMD_DECOMMIT: begin
            r.region_base = a;
            for (int i = 0; i < reg_count; i++)
               if (a >= reg_base[i] && {1'b0, a} < region_end(i)) begin
                  reg_comm[i] = 1'b0;
                  r.ok = 1'b1;
                  r.region_size = reg_size[i];
                  break;
               end
         end
         CMD_RELEASE: begin
            r.region_base = a;
            for (int i = 0; i < reg_count; i++)
               if (reg_base[i] == a) begin
                  r.ok = 1'b1;
                  r.region_size = reg_size[i];
                  for (int j = i; j + 1 < reg_count; j++) begin
                     reg_base[j] = reg_base[j+1];
                     reg_size[j] = reg_size[j+1];
                     reg_comm[j] = reg_comm[j+1];
                  end
                  reg_count--;
                  break;
               end
         end
         default: ;   // Unknown codes leave the table alone and answer all zeros.
      endcase
      return r;
   endfunction

   // Holds reset at the start, then releases it; afterwards the reset line stays low.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Result side: after each transfer, a random hold may keep tready low; calm keeps it high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_hold = calm ? 0 : $urandom_range(0, 4);
         else if (rsp_hold > 0) rsp_hold--;
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Compares each result transfer with the oldest expected one.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[100:0];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer: %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.ok !== want.ok || got.region_base !== want.region_base ||
                got.region_size !== want.region_size ||
                got.allocation_base !== want.allocation_base ||
                got.committed !== want.committed || got.reserved !== want.reserved ||
                got.was_committed !== want.was_committed ||
                got.zero_needed !== want.zero_needed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Result mismatch: ok %b/%b base %h/%h size %h/%h alloc %h/%h ",
                            "comm %b/%b resv %b/%b was %b/%b zero %b/%b (expected/actual)"},
                           want.ok, got.ok, want.region_base, got.region_base,
                           want.region_size, got.region_size, want.allocation_base,
                           got.allocation_base, want.committed, got.committed,
                           want.reserved, got.reserved, want.was_committed,
                           got.was_committed, want.zero_needed, got.zero_needed);
            end
         end
      end
   end

   // Sends one request. With no gap drawn, the valid line simply stays high into the
   // next transfer.
   task automatic send_req(logic [2:0] op, logic [31:0] a, logic [31:0] s,
                           logic c, logic td, logic z);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'd0, z, td, c, s, a};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(serve_request(op, a, s, c, td, z));
   endtask

   // Stops sending and waits until every expected result has been taken.
   task automatic drain_all();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Leaves the write channel valid; the caller drops it after the last write.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_BASE: win_lo = val;
         CSR_WINDOW_END:  win_hi = val;
         CSR_PAGE_SHIFT:  pg_shift = val[4:0];
         CSR_HEAP_READY:  heap_on = val[0];
         default: ;
      endcase
   endtask

   // Reprograms the whole register file; only done with the unit idle.
   task automatic set_window(logic [31:0] lo, logic [31:0] hi, logic [4:0] sh, logic rdy);
      drain_all();
      write_reg(CSR_WINDOW_BASE, lo);
      write_reg(CSR_WINDOW_END, hi);
      write_reg(CSR_PAGE_SHIFT, {27'd0, sh});
      write_reg(CSR_HEAP_READY, {31'd0, rdy});
      csr_valid <= 1'b0;
   endtask

   // Reset values of the registers: allocations fail and every query is outside the window.
   task automatic test_not_ready();
      send_req(CMD_FIXED, 32'h0, 32'h1000, 1'b1, 1'b0, 1'b1);
      send_req(CMD_ANY, 32'h0, 32'h1000, 1'b0, 1'b0, 1'b0);
      send_req(CMD_QUERY, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
      send_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
   endtask

   // Full-range window with the largest page: a slice from address 0 overflows.
   task automatic test_slice_clip();
      set_window(32'h0, 32'hFFFF_FFFF, 5'd31, 1'b1);
      send_req(CMD_QUERY, 32'h5, 32'h0, 1'b0, 1'b0, 1'b0);
      send_req(CMD_QUERY, 32'hFFFF_FFFE, 32'h0, 1'b0, 1'b0, 1'b0);
   endtask

   // One of each command and each failing corner in an ordinary window.
   task automatic test_directed();
      set_window(32'h1000_0000, 32'h1100_0000, 5'd12, 1'b1);
      send_req(CMD_FIXED, 32'h1000_2000, 32'h0, 1'b1, 1'b0, 1'b1);        // zero size
      send_req(CMD_FIXED, 32'h0FFF_F000, 32'h2000, 1'b0, 1'b0, 1'b0);     // below window
      send_req(CMD_FIXED, 32'h10FF_F000, 32'h2000, 1'b0, 1'b0, 1'b0);     // past window end
      send_req(CMD_FIXED, 32'h1000_2000, 32'h4000, 1'b1, 1'b0, 1'b1);     // fresh insert
      send_req(CMD_FIXED, 32'h1000_2000, 32'h4000, 1'b1, 1'b0, 1'b1);     // exact, committed
      send_req(CMD_FIXED, 32'h1000_3000, 32'h1000, 1'b0, 1'b0, 1'b0);     // contained
      send_req(CMD_FIXED, 32'h1000_5000, 32'h2000, 1'b1, 1'b0, 1'b0);     // partial overlap
      send_req(CMD_ANY, 32'h0, 32'h3000, 1'b0, 1'b0, 1'b1);
      send_req(CMD_ANY, 32'h0, 32'h3000, 1'b1, 1'b1, 1'b1);
      send_req(CMD_ANY, 32'h0, 32'h0100_0001, 1'b1, 1'b0, 1'b0);          // too large
      send_req(CMD_QUERY, 32'h1000_3456, 32'h0, 1'b0, 1'b0, 1'b0);        // tracked
      send_req(CMD_QUERY, 32'h1000_8123, 32'h0, 1'b0, 1'b0, 1'b0);        // tracked, placed region
      send_req(CMD_QUERY, 32'h2000_0000, 32'h0, 1'b0, 1'b0, 1'b0);        // outside window
      send_req(CMD_DECOMMIT, 32'h1000_5FFF, 32'h0, 1'b0, 1'b0, 1'b0);
      send_req(CMD_DECOMMIT, 32'h1000_9000, 32'h0, 1'b0, 1'b0, 1'b0);     // nothing there
      send_req(CMD_FIXED, 32'h1000_2000, 32'h1000, 1'b1, 1'b0, 1'b1);     // recommit, zero
      send_req(CMD_RELEASE, 32'h1000_2000, 32'h0, 1'b0, 1'b0, 1'b0);
      send_req(CMD_RELEASE, 32'h1000_2000, 32'h0, 1'b0, 1'b0, 1'b0);      // already gone
      send_req(3'd5, 32'h1000_0000, 32'h1000, 1'b0, 1'b0, 1'b0);
   endtask

   // Fills the table to the last slot, tries past it, then empties part of it.
   task automatic test_full_table();
      int tries;
      tries = 0;
      while (reg_count < SLOTS && tries < 200) begin
         send_req(CMD_ANY, $urandom, {20'($urandom_range(1, 4)), 12'h0},
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
         tries++;
      end
      send_req(CMD_ANY, 32'h0, 32'h1000, 1'b1, 1'b0, 1'b0);
      send_req(CMD_FIXED, 32'h10F0_0000, 32'h1000, 1'b1, 1'b0, 1'b1);
      for (int k = 0; k < 40 && reg_count > 0; k++)
         send_req(CMD_RELEASE, reg_base[$urandom_range(0, reg_count - 1)], 32'h0,
                  1'b0, 1'b0, 1'b0);
   endtask

   function automatic logic [31:0] pick_addr();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 3 && reg_count > 0) return reg_base[$urandom_range(0, reg_count - 1)];
      if (mode < 5 && reg_count > 0)
         return reg_base[$urandom_range(0, reg_count - 1)] + $urandom_range(0, 32'h3000);
      if (mode < 9)
         return win_lo + {20'($urandom_range(0, 511)), 12'h0} +
                $urandom_range(0, 3) * 32'h800;
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_size();
      int mode;
      mode = $urandom_range(0, 19);
      if (mode == 0) return 32'h0;
      if (mode == 1) return $urandom;
      if (mode < 5) return $urandom_range(1, 32'h3000);
      return {20'($urandom_range(1, 16)), 12'h0};
   endfunction

   // Random traffic; allocations outweigh releases so the table stays busy.
   task automatic test_random(int count, bit pause_midway);
      int w;
      logic [2:0] op;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         if (pause_midway && n == count / 2) drain_all();
         w = $urandom_range(0, 99);
         if (w < 25) op = CMD_FIXED;
         else if (w < 45) op = CMD_ANY;
         else if (w < 65) op = CMD_QUERY;
         else if (w < 75) op = CMD_DECOMMIT;
         else if (w < 97) op = CMD_RELEASE;
         else op = 3'($urandom_range(5, 7));
         send_req(op, pick_addr(), pick_size(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      calm = 1'b0;
   endtask

   initial begin
      win_lo = 32'h0;
      win_hi = 32'h0;
      pg_shift = 5'd12;
      heap_on = 1'b0;
      reg_count = 0;
      mismatches = 0;
      calm = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         reg_base[i] = '0;
         reg_size[i] = '0;
         reg_comm[i] = 1'b0;
      end
      @(posedge clock);
      while (reset) @(posedge clock);

      test_not_ready();
      test_slice_clip();
      test_directed();
      test_full_table();
      set_window(32'h4000_0000, 32'h4020_0000, 5'd12, 1'b1);
      test_random(800, 1'b1);
      set_window(32'h0, 32'hFFFF_FFFF, 5'd31, 1'b1);
      test_random(300, 1'b0);
      set_window(32'hFFF0_0000, 32'hFFFF_FFFF, 5'd0, 1'b1);
      test_random(300, 1'b0);
      set_window(32'h8000_0000, 32'h7000_0000, 5'd20, 1'b1);   // inverted window
      test_random(150, 1'b0);
      set_window(32'h4000_0000, 32'h4020_0000, 5'd16, 1'b0);  // heap not ready
      test_random(150, 1'b0);
      set_window(32'h4000_0000, 32'h4040_0000, 5'd13, 1'b1);
      test_random(200, 1'b0);
      drain_all();
      repeat (140) @(posedge clock);

      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: fails a run that has not finished when the delay ends.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/vrt_pkg.sv
sv/vrt_cell.sv
sv/vrt_ctrl.sv
sv/virtual_region_tracker_unit.sv
tb/virtual_region_tracker_unit_tb.sv
